### rtl/rcwc_pkg.sv
// Shared types and constants for the Reno congestion window controller.
// No dependencies; the RTL uses scoped names, the testbench imports it.
package rcwc_pkg;

    // Field widths
    localparam int unsigned OP_W    = 2;
    localparam int unsigned WIN_W   = 16;
    localparam int unsigned THR_W   = 24;
    localparam int unsigned ACK_W   = 32;
    localparam int unsigned DUP_W   = 3;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 24;

    // Event codes
    localparam logic [OP_W-1:0] OP_RECV    = 2'd0;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd1;
    localparam logic [OP_W-1:0] OP_SENT    = 2'd2;

    // Congestion modes
    localparam logic [MODE_W-1:0] MODE_SS = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CA = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FR = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IN_FLIGHT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_THRESH   = 1'b1;

    // Saturation limits and reset values
    localparam logic [WIN_W-1:0] WIN_MAX = 16'hFFFF;
    localparam logic [THR_W-1:0] THR_MAX = 24'hFF_FFFF;
    localparam logic [DUP_W-1:0] DUP_MAX = 3'd7;
    localparam logic [WIN_W-1:0] MAX_IN_FLIGHT_RST = 16'd25;
    localparam logic [THR_W-1:0] INIT_THRESH_RST   = 24'd1000;
    localparam logic [ACK_W-1:0] HIGHEST_ACK_RST   = 32'd1;

    // One input beat
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             ack_flag;
        logic             fin_flag;
        logic [ACK_W-1:0] ack_number;
    } t_event;

    // One result beat
    typedef struct packed {
        logic [WIN_W-1:0]  window_segments;
        logic [THR_W-1:0]  threshold_bytes;
        logic [WIN_W-1:0]  segments_in_flight;
        logic              may_send;
        logic [MODE_W-1:0] mode;
        logic              retransmit;
        logic              rewind;
        logic [ACK_W-1:0]  resend_offset;
        logic              transfer_done;
    } t_status;

    // Register write bundle
    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

### rtl/rcwc_event_if.sv
// Valid/ready channel carrying event beats into the controller.
// Depends on rcwc_pkg for the payload type.
interface rcwc_event_if;
    logic            valid;
    logic            ready;
    rcwc_pkg::t_event payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/rcwc_status_if.sv
// Valid/ready channel carrying status beats out of the controller.
// Depends on rcwc_pkg for the payload type.
interface rcwc_status_if;
    logic             valid;
    logic             ready;
    rcwc_pkg::t_status payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/reno_congestion_window_control.sv
// Reno congestion window controller, sender side. Each event beat (received
// packet, retransmit timeout or segment sent) passes an input register, one
// pass of next-state logic and a result register, so one event is taken
// every cycle unless the result side stalls; its status beat is loaded
// into the result register as the beat leaves the input register. The rate
// is set by the update of the window, threshold and in-flight registers,
// and a stalled result only blocks input once both registers are full.
// Register writes (max_in_flight, initial threshold) take effect at once and
// must be issued while no event is in progress.
module reno_congestion_window_control #(
    parameter int unsigned SEGMENT_BYTES = 100,
    parameter int unsigned DUP_ACK_LIMIT = 3
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    rcwc_event_if.sink                             i_evt,
    rcwc_status_if.source                          o_sts,
    input  logic                                   i_cfg_we,
    input  logic [rcwc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [rcwc_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    logic               evt_valid;
    rcwc_pkg::t_event   evt;
    logic               out_free;
    logic               step;
    rcwc_pkg::t_status  sts_next;
    rcwc_pkg::t_cfg_wr  cfg;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    // Advance a beat when the result register can take it
    assign step = evt_valid && out_free;

    rcwc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .evt_in  (i_evt),
        .i_take  (step),
        .o_valid (evt_valid),
        .o_evt   (evt)
    );

    rcwc_core #(
        .SEGMENT_BYTES (SEGMENT_BYTES),
        .DUP_ACK_LIMIT (DUP_ACK_LIMIT)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_evt   (evt),
        .i_cfg   (cfg),
        .o_sts   (sts_next)
    );

    rcwc_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step),
        .i_sts   (sts_next),
        .o_free  (out_free),
        .sts_out (o_sts)
    );

endmodule

### rtl/rcwc_in_stage.sv
// Input register: holds one event beat until the core takes it.
// Depends on rcwc_pkg and rcwc_event_if.
module rcwc_in_stage (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rcwc_event_if.sink           evt_in,
    input  logic                 i_take,
    output logic                 o_valid,
    output rcwc_pkg::t_event     o_evt
);

    logic             r_valid;
    rcwc_pkg::t_event r_evt;

    // Room whenever empty or the held beat leaves this cycle; none during reset
    assign evt_in.ready = i_rst_n && (!r_valid || i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (evt_in.ready) begin
            r_valid <= evt_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (evt_in.valid && evt_in.ready) begin
            r_evt <= evt_in.payload;
        end
    end

    assign o_valid = r_valid;
    assign o_evt   = r_evt;

endmodule

### rtl/rcwc_core.sv
// Congestion state registers and the single-pass next-state logic.
// Depends on rcwc_pkg.
module rcwc_core #(
    parameter int unsigned SEGMENT_BYTES = 100,
    parameter int unsigned DUP_ACK_LIMIT = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  rcwc_pkg::t_event   i_evt,
    input  rcwc_pkg::t_cfg_wr  i_cfg,
    output rcwc_pkg::t_status  o_sts
);

    localparam int unsigned WW = rcwc_pkg::WIN_W;
    localparam int unsigned TW = rcwc_pkg::THR_W;
    localparam int unsigned AW = rcwc_pkg::ACK_W;

    // Reciprocals for exact floor division by the segment size
    localparam int unsigned SEG_L  = $clog2(SEGMENT_BYTES);
    localparam int unsigned THR_K  = TW + SEG_L;
    localparam int unsigned ACK_K  = AW + SEG_L;
    localparam logic [TW:0] THR_RECIP = (TW+1)'(((65'd1 << THR_K) / SEGMENT_BYTES) + 65'd1);
    localparam logic [AW:0] ACK_RECIP = (AW+1)'(((65'd1 << ACK_K) / SEGMENT_BYTES) + 65'd1);
    localparam logic [WW-1:0] SEG_W   = WW'(SEGMENT_BYTES);
    localparam logic [TW-1:0] THR_SAT_Q = TW'(24'hFF_FFFF / SEGMENT_BYTES);
    localparam logic [rcwc_pkg::DUP_W-1:0] DUP_LIMIT = DUP_ACK_LIMIT[rcwc_pkg::DUP_W-1:0];

    // State
    logic [rcwc_pkg::MODE_W-1:0] r_mode, n_mode;
    logic [WW-1:0]               r_window, n_window;
    logic [TW-1:0]               r_threshold, n_threshold;
    logic [rcwc_pkg::DUP_W-1:0]  r_dup, n_dup;
    logic [WW-1:0]               r_avoid, n_avoid;
    logic [AW-1:0]               r_highest_ack, n_highest_ack;
    logic [WW-1:0]               r_in_flight, n_in_flight;
    logic [WW-1:0]               r_max_in_flight, n_max_in_flight;

    // Datapath terms
    logic [2*WW-1:0]    win_prod;
    logic [2*WW:0]      ss_prod;
    logic [2*WW-1:0]    half_prod;
    logic [2*WW-1:0]    to_half;
    logic               half_over;
    logic [TW-1:0]      fire_q;
    logic [TW:0]        fire_sum;
    logic [WW-1:0]      fire_win;
    logic [2*TW:0]      thr_prod;
    logic [2*TW:0]      thr_shift;
    logic [TW-1:0]      thr_q;
    logic [AW-1:0]      ack_delta;
    logic [2*AW:0]      ack_prod;
    logic [2*AW:0]      ack_shift;
    logic [AW-1:0]      ack_q;
    logic [WW-1:0]      fr_flight;
    logic [WW-1:0]      win_inc;
    logic [WW-1:0]      avoid_inc;
    logic [rcwc_pkg::DUP_W-1:0] dup_inc;
    logic               is_dup;
    logic               fire;
    logic               retx, rew, done;

    // Window times segment size, shared by the threshold terms
    assign win_prod  = {{WW{1'b0}}, r_window} * {{WW{1'b0}}, SEG_W};
    assign ss_prod   = (r_window == rcwc_pkg::WIN_MAX) ? {1'b0, win_prod}
                     : {1'b0, win_prod} + (2*WW+1)'(SEG_W);
    // (window/2)*segment, and window*segment/2
    assign half_prod = (win_prod - (r_window[0] ? (2*WW)'(SEG_W) : '0)) >> 1;
    assign to_half   = win_prod >> 1;
    assign half_over = half_prod > (2*WW)'(rcwc_pkg::THR_MAX);

    // Fast retransmit window: threshold/segment is window/2 unless saturated
    assign fire_q   = half_over ? THR_SAT_Q : TW'(r_window >> 1);
    assign fire_sum = {1'b0, fire_q} + (TW+1)'(3);
    assign fire_win = (fire_sum > (TW+1)'(rcwc_pkg::WIN_MAX)) ? rcwc_pkg::WIN_MAX
                    : fire_sum[WW-1:0];

    // Deflated window after recovery: threshold / segment
    assign thr_prod  = {{(TW+1){1'b0}}, r_threshold} * {{TW{1'b0}}, THR_RECIP};
    assign thr_shift = thr_prod >> THR_K;
    assign thr_q     = thr_shift[TW-1:0];

    // Segments covered by a new ACK in recovery
    assign ack_delta = i_evt.ack_number - r_highest_ack;
    assign ack_prod  = {{(AW+1){1'b0}}, ack_delta} * {{AW{1'b0}}, ACK_RECIP};
    assign ack_shift = ack_prod >> ACK_K;
    assign ack_q     = ack_shift[AW-1:0];
    assign fr_flight = (ack_q >= AW'(r_in_flight)) ? '0 : r_in_flight - ack_q[WW-1:0];

    assign win_inc   = (r_window == rcwc_pkg::WIN_MAX) ? r_window : r_window + 1'b1;
    assign avoid_inc = r_avoid + 1'b1;
    assign dup_inc   = r_dup + 1'b1;
    assign is_dup    = r_highest_ack >= i_evt.ack_number;
    assign fire      = (r_dup != rcwc_pkg::DUP_MAX) && (dup_inc == DUP_LIMIT);

    // Next state for one event
    always_comb begin
        n_mode          = r_mode;
        n_window        = r_window;
        n_threshold     = r_threshold;
        n_dup           = r_dup;
        n_avoid         = r_avoid;
        n_highest_ack   = r_highest_ack;
        n_in_flight     = r_in_flight;
        n_max_in_flight = r_max_in_flight;
        retx            = 1'b0;
        rew             = 1'b0;
        done            = 1'b0;
        // The held beat only acts when it is stepped, not on a bare register write
        if (i_step) begin
            case (i_evt.op)
                rcwc_pkg::OP_RECV: begin
                    if (i_evt.fin_flag && i_evt.ack_flag) begin
                        done = 1'b1;
                    end else if (i_evt.ack_flag && is_dup) begin
                        if (r_dup != rcwc_pkg::DUP_MAX) begin
                            n_dup = dup_inc;
                        end
                        if (r_mode == rcwc_pkg::MODE_FR) begin
                            n_window = win_inc;
                        end else if (fire) begin
                            n_threshold = half_over ? rcwc_pkg::THR_MAX : half_prod[TW-1:0];
                            n_window    = fire_win;
                            n_in_flight = fire_win - WW'(3);
                            n_mode      = rcwc_pkg::MODE_FR;
                            retx        = 1'b1;
                        end
                    end else if (i_evt.ack_flag) begin
                        n_highest_ack = i_evt.ack_number;
                        n_dup         = '0;
                        if (r_mode == rcwc_pkg::MODE_SS) begin
                            n_window = win_inc;
                            if (ss_prod >= (2*WW+1)'(r_threshold)) begin
                                n_avoid = '0;
                                n_mode  = rcwc_pkg::MODE_CA;
                            end
                            n_in_flight = (r_in_flight == '0) ? '0 : r_in_flight - 1'b1;
                        end else if (r_mode == rcwc_pkg::MODE_CA) begin
                            n_avoid = avoid_inc;
                            if (r_window == avoid_inc) begin
                                n_window = win_inc;
                                n_avoid  = '0;
                            end
                            n_in_flight = (r_in_flight == '0) ? '0 : r_in_flight - 1'b1;
                        end else begin
                            n_window    = (thr_q > TW'(rcwc_pkg::WIN_MAX)) ? rcwc_pkg::WIN_MAX
                                        : thr_q[WW-1:0];
                            n_avoid     = '0;
                            n_mode      = rcwc_pkg::MODE_CA;
                            n_in_flight = fr_flight;
                        end
                    end
                end
                rcwc_pkg::OP_TIMEOUT: begin
                    n_threshold = (to_half > (2*WW)'(rcwc_pkg::THR_MAX)) ? rcwc_pkg::THR_MAX
                                : to_half[TW-1:0];
                    n_window    = WW'(1);
                    n_dup       = '0;
                    n_in_flight = '0;
                    n_mode      = rcwc_pkg::MODE_SS;
                    rew         = 1'b1;
                end
                rcwc_pkg::OP_SENT: begin
                    if (r_in_flight != rcwc_pkg::WIN_MAX) begin
                        n_in_flight = r_in_flight + 1'b1;
                    end
                end
                default: begin
                    // unused code: status only
                end
            endcase
        end

        // User must write registers only while no beat is in progress, not enforced
        if (i_cfg.we) begin
            case (i_cfg.index)
                rcwc_pkg::CFG_MAX_IN_FLIGHT: n_max_in_flight = i_cfg.data[WW-1:0];
                rcwc_pkg::CFG_INIT_THRESH:   n_threshold     = i_cfg.data[TW-1:0];
                default: ;
            endcase
        end
    end

    // Result from the post-event state
    always_comb begin
        o_sts.window_segments    = n_window;
        o_sts.threshold_bytes    = n_threshold;
        o_sts.segments_in_flight = n_in_flight;
        o_sts.may_send           = (n_in_flight < n_window) && (n_in_flight < r_max_in_flight);
        o_sts.mode               = n_mode;
        o_sts.retransmit         = retx;
        o_sts.rewind             = rew;
        o_sts.resend_offset      = n_highest_ack - 1'b1;
        o_sts.transfer_done      = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= rcwc_pkg::MODE_SS;
            r_window        <= WW'(1);
            r_threshold     <= rcwc_pkg::INIT_THRESH_RST;
            r_dup           <= '0;
            r_avoid         <= '0;
            r_highest_ack   <= rcwc_pkg::HIGHEST_ACK_RST;
            r_in_flight     <= '0;
            r_max_in_flight <= rcwc_pkg::MAX_IN_FLIGHT_RST;
        end else if (i_step || i_cfg.we) begin
            r_mode          <= n_mode;
            r_window        <= n_window;
            r_threshold     <= n_threshold;
            r_dup           <= n_dup;
            r_avoid         <= n_avoid;
            r_highest_ack   <= n_highest_ack;
            r_in_flight     <= n_in_flight;
            r_max_in_flight <= n_max_in_flight;
        end
    end

    // Checks
    a_sent_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_cfg.we && i_evt.op == rcwc_pkg::OP_SENT
            && r_in_flight != rcwc_pkg::WIN_MAX
        |=> r_in_flight == $past(r_in_flight) + 1'b1)
        else $error("segment sent not counted");

    a_retx_enters_fr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_sts.retransmit |=> r_mode == rcwc_pkg::MODE_FR)
        else $error("retransmit without fast recovery");

    a_rewind_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_sts.rewind
        |=> r_window == WW'(1) && r_in_flight == '0 && r_mode == rcwc_pkg::MODE_SS)
        else $error("timeout did not restart slow start");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_cfg.we && o_sts.transfer_done
        |=> $stable(r_window) && $stable(r_threshold) && $stable(r_in_flight)
            && $stable(r_highest_ack) && $stable(r_mode))
        else $error("final packet changed state");

endmodule

### rtl/rcwc_out_stage.sv
// Result register: holds one status beat until the sink takes it.
// Depends on rcwc_pkg and rcwc_status_if.
module rcwc_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  rcwc_pkg::t_status  i_sts,
    output logic               o_free,
    rcwc_status_if.source      sts_out
);

    logic              r_valid;
    rcwc_pkg::t_status r_sts;

    // Free when empty or the held beat is taken this cycle
    assign o_free = !r_valid || sts_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sts <= i_sts;
        end
    end

    assign sts_out.valid   = r_valid;
    assign sts_out.payload = r_sts;

endmodule

### dv/tb_reno_congestion_window_control.sv
// Self-checking testbench for the Reno congestion window controller: a directed table, then mostly
// well-formed random ACK/send/timeout traffic under several register settings, with random stalls.
// Depends on rcwc_pkg, rcwc_event_if, rcwc_status_if and reno_congestion_window_control.
`timescale 1ns / 1ps

module tb_reno_congestion_window_control;
    import rcwc_pkg::*;

    localparam int unsigned SEG_BYTES    = 100;
    localparam int unsigned DUP_LIMIT    = 3;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int PHASE_ITEMS  = 305;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        t_event  ev;
        bit      typed;
        t_status want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rcwc_event_if  evt_if();
    rcwc_status_if sts_if();

    reno_congestion_window_control #(
        .SEGMENT_BYTES (SEG_BYTES),
        .DUP_ACK_LIMIT (DUP_LIMIT)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt       (evt_if),
        .o_sts       (sts_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor state and register copies
    logic [MODE_W-1:0] pr_mode;
    logic [WIN_W-1:0]  pr_win;
    logic [THR_W-1:0]  pr_thr;
    logic [DUP_W-1:0]  pr_dup;
    logic [WIN_W-1:0]  pr_avoid;
    logic [ACK_W-1:0]  pr_hiack;
    logic [WIN_W-1:0]  pr_flight;
    logic [WIN_W-1:0]  cfg_flight_cap;

    t_status  status_due[$];
    t_dir_row dir_rows[$];

    int err_count;
    int n_events;
    int n_results;
    int n_retx;
    int n_rewind;
    int n_done;
    int n_settings;
    int dup_storm;
    bit send_steady;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [WIN_W-1:0] clip_win(input logic [63:0] v);
        if (v > 64'hFFFF) return WIN_MAX;
        return v[WIN_W-1:0];
    endfunction

    function automatic logic [THR_W-1:0] clip_thr(input logic [63:0] v);
        if (v > 64'hFF_FFFF) return THR_MAX;
        return v[THR_W-1:0];
    endfunction

    // in-flight stops at zero
    function automatic logic [WIN_W-1:0] drop_flight(input logic [WIN_W-1:0] cur,
                                                     input logic [63:0] n);
        if (n >= 64'(cur)) return '0;
        return cur - n[WIN_W-1:0];
    endfunction

    function automatic t_event mk_event(input logic [OP_W-1:0] op, input logic ack,
                                        input logic fin, input logic [ACK_W-1:0] num);
        t_event ev;
        ev.op         = op;
        ev.ack_flag   = ack;
        ev.fin_flag   = fin;
        ev.ack_number = num;
        return ev;
    endfunction

    function automatic t_status mk_status(input logic [WIN_W-1:0] win,
                                          input logic [THR_W-1:0] thr,
                                          input logic [WIN_W-1:0] flight, input logic may,
                                          input logic [MODE_W-1:0] mode, input logic retx,
                                          input logic rew, input logic [ACK_W-1:0] offset,
                                          input logic done);
        t_status st;
        st.window_segments    = win;
        st.threshold_bytes    = thr;
        st.segments_in_flight = flight;
        st.may_send           = may;
        st.mode               = mode;
        st.retransmit         = retx;
        st.rewind             = rew;
        st.resend_offset      = offset;
        st.transfer_done      = done;
        return st;
    endfunction

    task automatic reset_predictor();
        cfg_flight_cap = MAX_IN_FLIGHT_RST;
        pr_mode   = MODE_SS;
        pr_win    = 16'd1;
        pr_thr    = INIT_THRESH_RST;
        pr_dup    = '0;
        pr_avoid  = '0;
        pr_hiack  = HIGHEST_ACK_RST;
        pr_flight = '0;
    endtask

    // Next-state and status for one accepted event beat
    task automatic predict_status(input t_event ev, output t_status st);
        logic        retx;
        logic        rew;
        logic        done;
        logic        fire;
        logic [63:0] wide;
        logic [31:0] delta;
        retx = 1'b0;
        rew  = 1'b0;
        done = 1'b0;
        case (ev.op)
            OP_RECV: begin
                if (ev.fin_flag && ev.ack_flag) begin
                    done = 1'b1;
                end else if (ev.ack_flag && pr_hiack >= ev.ack_number) begin
                    // duplicate ACK
                    fire = 1'b0;
                    if (pr_dup < DUP_MAX) begin
                        pr_dup = pr_dup + 3'd1;
                        fire   = (pr_dup == DUP_LIMIT);
                    end
                    if (pr_mode == MODE_FR) begin
                        pr_win = clip_win({48'd0, pr_win} + 64'd1);
                    end else if (fire) begin
                        wide      = 64'(pr_win) / 64'd2;
                        wide      = wide * SEG_BYTES;
                        pr_thr    = clip_thr(wide);
                        wide      = 64'(pr_thr);
                        wide      = wide / SEG_BYTES + 64'd3;
                        pr_win    = clip_win(wide);
                        pr_flight = pr_win - 16'd3;
                        pr_mode   = MODE_FR;
                        retx      = 1'b1;
                    end
                end else if (ev.ack_flag) begin
                    // new ACK
                    delta    = ev.ack_number - pr_hiack;
                    pr_hiack = ev.ack_number;
                    pr_dup   = '0;
                    if (pr_mode == MODE_SS) begin
                        pr_win = clip_win({48'd0, pr_win} + 64'd1);
                        wide   = 64'(pr_win);
                        wide   = wide * SEG_BYTES;
                        if (wide >= 64'(pr_thr)) begin
                            pr_avoid = '0;
                            pr_mode  = MODE_CA;
                        end
                        pr_flight = drop_flight(pr_flight, 64'd1);
                    end else if (pr_mode == MODE_CA) begin
                        pr_avoid = pr_avoid + 16'd1;
                        if (pr_win == pr_avoid) begin
                            pr_win   = clip_win({48'd0, pr_win} + 64'd1);
                            pr_avoid = '0;
                        end
                        pr_flight = drop_flight(pr_flight, 64'd1);
                    end else begin
                        // deflate out of fast recovery
                        wide      = 64'(pr_thr);
                        pr_win    = clip_win(wide / SEG_BYTES);
                        pr_avoid  = '0;
                        pr_mode   = MODE_CA;
                        wide      = 64'(delta);
                        pr_flight = drop_flight(pr_flight, wide / SEG_BYTES);
                    end
                end
            end
            OP_TIMEOUT: begin
                wide      = 64'(pr_win);
                wide      = wide * SEG_BYTES / 64'd2;
                pr_thr    = clip_thr(wide);
                pr_win    = 16'd1;
                pr_dup    = '0;
                pr_flight = '0;
                pr_mode   = MODE_SS;
                rew       = 1'b1;
            end
            OP_SENT: begin
                if (pr_flight < WIN_MAX) pr_flight = pr_flight + 16'd1;
            end
            default: begin
            end
        endcase
        st = mk_status(pr_win, pr_thr, pr_flight,
                       (pr_flight < pr_win) && (pr_flight < cfg_flight_cap),
                       pr_mode, retx, rew, pr_hiack - 32'd1, done);
    endtask

    // Random traffic, mostly well-formed against the current highest ack
    function automatic t_event next_random_event();
        int          pick;
        logic [31:0] back;
        logic [31:0] ackn;
        if (dup_storm > 0) begin
            dup_storm--;
            return mk_event(OP_RECV, 1'b1, 1'b0, pr_hiack);
        end
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            return mk_event(OP_SENT, 1'($urandom), 1'($urandom), $urandom);
        end else if (pick < 62) begin
            ackn = pr_hiack + SEG_BYTES * $urandom_range(1, 4);
            if ($urandom_range(0, 3) == 0) ackn = ackn + $urandom_range(0, 99);
            return mk_event(OP_RECV, 1'b1, 1'b0, ackn);
        end else if (pick < 78) begin
            back = 32'd0;
            if ($urandom_range(0, 1) == 0)
                back = $urandom_range(0, pr_hiack > 500 ? 500 : pr_hiack);
            return mk_event(OP_RECV, 1'b1, 1'b0, pr_hiack - back);
        end else if (pick < 83) begin
            dup_storm = $urandom_range(2, 8);
            return mk_event(OP_RECV, 1'b1, 1'b0, pr_hiack);
        end else if (pick < 87) begin
            return mk_event(OP_TIMEOUT, 1'($urandom), 1'($urandom), $urandom);
        end else if (pick < 93) begin
            return mk_event(OP_RECV, 1'b0, 1'($urandom), $urandom);
        end else if (pick < 97) begin
            return mk_event(OP_RECV, 1'b1, 1'b1, $urandom);
        end
        return mk_event(OP_SPARE, 1'($urandom), 1'($urandom), $urandom);
    endfunction

    task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    task automatic check_status(input t_status got);
        t_status want;
        n_results++;
        if (got.retransmit)    n_retx++;
        if (got.rewind)        n_rewind++;
        if (got.transfer_done) n_done++;
        if (status_due.size() == 0) begin
            err_count++;
            $display("%0t: status beat with nothing expected, got %0h", $time, got);
        end else begin
            want = status_due.pop_front();
            cmp_field("window_segments", 32'(want.window_segments),
                      32'(got.window_segments));
            cmp_field("threshold_bytes", 32'(want.threshold_bytes),
                      32'(got.threshold_bytes));
            cmp_field("segments_in_flight", 32'(want.segments_in_flight),
                      32'(got.segments_in_flight));
            cmp_field("may_send", 32'(want.may_send), 32'(got.may_send));
            cmp_field("mode", 32'(want.mode), 32'(got.mode));
            cmp_field("retransmit", 32'(want.retransmit), 32'(got.retransmit));
            cmp_field("rewind", 32'(want.rewind), 32'(got.rewind));
            cmp_field("resend_offset", want.resend_offset, got.resend_offset);
            cmp_field("transfer_done", 32'(want.transfer_done), 32'(got.transfer_done));
        end
    endtask

    // One event beat; valid stays high across back-to-back beats
    task automatic send_event(input t_event ev, input bit typed, input t_status want);
        int      gap;
        t_status st;
        if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            evt_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        evt_if.valid   <= 1'b1;
        evt_if.payload <= ev;
        do @(posedge i_clk); while (!evt_if.ready);
        predict_status(ev, st);
        status_due.push_back(typed ? want : st);
        n_events++;
    endtask

    // Waits for a clock edge before testing, so valid is never lowered and raised in one step
    task automatic wait_drained();
        do @(posedge i_clk); while (status_due.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_MAX_IN_FLIGHT) begin
            cfg_flight_cap = data[WIN_W-1:0];
        end else begin
            pr_thr = data;
        end
    endtask

    // Registers are only touched once the pipeline is empty
    task automatic apply_setting(input logic [WIN_W-1:0] cap, input logic [THR_W-1:0] thr);
        evt_if.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(CFG_MAX_IN_FLIGHT, {8'd0, cap});
        write_reg(CFG_INIT_THRESH, thr);
        n_settings++;
    endtask

    task automatic add_row(input t_event ev, input bit typed, input t_status want);
        t_dir_row row;
        row.ev    = ev;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    // Result side: random stalls with occasional stall-free stretches
    initial begin
        int      gap;
        bit      steady;
        t_status got;
        steady = 1'b0;
        sts_if.ready <= 1'b0;
        wait (i_rst_n);
        forever begin
            if ($urandom_range(0, 39) == 0) steady = !steady;
            gap = steady ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                sts_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            sts_if.ready <= 1'b1;
            do @(posedge i_clk); while (!sts_if.valid);
            got = sts_if.payload;
            check_status(got);
        end
    end

    // Stimulus
    initial begin
        t_status base;
        t_status none;
        t_event  ev;
        err_count   = 0;
        n_events    = 0;
        n_results   = 0;
        n_retx      = 0;
        n_rewind    = 0;
        n_done      = 0;
        n_settings  = 0;
        dup_storm   = 0;
        send_steady = 1'b0;
        none        = '0;
        reset_predictor();
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_data     <= '0;
        evt_if.valid   <= 1'b0;
        evt_if.payload <= '0;

        // Directed table, walked from reset values
        base = mk_status(16'd1, 24'd1000, 16'd0, 1'b1, MODE_SS, 1'b0, 1'b0, 32'd0, 1'b0);
        add_row(mk_event(OP_SPARE, 1'b0, 1'b0, 32'd0), 1'b1, base);
        // non-ACK packet, all number bits high
        add_row(mk_event(OP_RECV, 1'b0, 1'b0, 32'hFFFF_FFFF), 1'b1, base);
        // final packet
        add_row(mk_event(OP_RECV, 1'b1, 1'b1, 32'hFFFF_FFFF), 1'b1,
                mk_status(16'd1, 24'd1000, 16'd0, 1'b1, MODE_SS, 1'b0, 1'b0, 32'd0, 1'b1));
        add_row(mk_event(OP_RECV, 1'b0, 1'b1, 32'd0), 1'b1, base);
        add_row(mk_event(OP_SENT, 1'b0, 1'b0, 32'd0), 1'b1,
                mk_status(16'd1, 24'd1000, 16'd1, 1'b0, MODE_SS, 1'b0, 1'b0, 32'd0, 1'b0));
        add_row(mk_event(OP_RECV, 1'b1, 1'b0, 32'd0), 1'b0, none);
        add_row(mk_event(OP_RECV, 1'b1, 1'b0, 32'd101), 1'b0, none);
        add_row(mk_event(OP_TIMEOUT, 1'b0, 1'b0, 32'd0), 1'b1,
                mk_status(16'd1, 24'd100, 16'd0, 1'b1, MODE_SS, 1'b0, 1'b1, 32'd100, 1'b0));
        // into avoidance, in-flight held at zero
        add_row(mk_event(OP_RECV, 1'b1, 1'b0, 32'd201), 1'b0, none);
        add_row(mk_event(OP_RECV, 1'b1, 1'b0, 32'd301), 1'b0, none);
        add_row(mk_event(OP_RECV, 1'b1, 1'b0, 32'd401), 1'b0, none);
        repeat (3) add_row(mk_event(OP_SENT, 1'b0, 1'b0, 32'd0), 1'b0, none);
        // three duplicates, the last one below the highest ack
        add_row(mk_event(OP_RECV, 1'b1, 1'b0, 32'd401), 1'b0, none);
        add_row(mk_event(OP_RECV, 1'b1, 1'b0, 32'd401), 1'b0, none);
        add_row(mk_event(OP_RECV, 1'b1, 1'b0, 32'd300), 1'b0, none);
        // window inflation in recovery, duplicate count runs up and holds
        repeat (5) add_row(mk_event(OP_RECV, 1'b1, 1'b0, 32'd401), 1'b0, none);
        // new ACK deflates the window
        add_row(mk_event(OP_RECV, 1'b1, 1'b0, 32'd901), 1'b0, none);
        add_row(mk_event(OP_TIMEOUT, 1'b1, 1'b1, 32'hFFFF_FFFF), 1'b0, none);
        add_row(mk_event(OP_SPARE, 1'b1, 1'b1, 32'hFFFF_FFFF), 1'b0, none);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) send_event(dir_rows[r].ev, dir_rows[r].typed, dir_rows[r].want);

        // Random phases, extremes of both registers first
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: apply_setting(16'd1, 24'd0);
                1: apply_setting(WIN_MAX, THR_MAX);
                2: apply_setting(16'($urandom_range(2, 40)), 24'($urandom_range(0, 3000)));
                3: apply_setting(16'($urandom_range(1, 65535)), 24'($urandom));
                default: apply_setting(16'($urandom_range(4, 16)), 24'($urandom_range(100, 2000)));
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                ev = next_random_event();
                send_event(ev, 1'b0, none);
                // hold off until every status beat is back
                if ((ph == 0 && i == PHASE_ITEMS / 2) || $urandom_range(0, 149) == 0) begin
                    evt_if.valid <= 1'b0;
                    wait_drained();
                end
            end
        end

        // Highest ack pushed to the top of the number space
        send_event(mk_event(OP_RECV, 1'b1, 1'b0, 32'hFFFF_FFFF), 1'b0, none);
        repeat (6) send_event(mk_event(OP_RECV, 1'b1, 1'b0, $urandom), 1'b0, none);
        send_event(mk_event(OP_TIMEOUT, 1'b0, 1'b0, 32'd0), 1'b0, none);

        evt_if.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d events and %0d status beats over %0d register settings plus reset.",
                 n_events, n_results, n_settings);
        $display("Seen %0d fast retransmits, %0d timeouts, %0d finished transfers.",
                 n_retx, n_rewind, n_done);
        if (err_count == 0 && status_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
